/* src/acer_pkg.sv */
// Shared constants, register codes and reset values for the clip/echo/reverb chain.
package acer_pkg;

    // Default sizing handed to the top level
    localparam int STORE_WORDS_DEF = 65536;
    localparam int SAMPLE_BITS_DEF = 12;

    // Configuration port geometry
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 17;
    localparam int EN_BITS       = 3;
    localparam int CLIP_BITS     = 10;
    localparam int LEN_BITS      = 17;

    // Datapath constants
    localparam int CLIP_CENTER = 1023;
    localparam int CENTER_BITS = 11;   // holds the clip center plus the widest half width
    localparam int PWM_BITS    = 6;
    localparam int COMB_LANES  = 4;

    // Bit positions inside effect_enables
    localparam int EN_DIST   = 0;
    localparam int EN_ECHO   = 1;
    localparam int EN_REVERB = 2;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ENABLES        = 3'd0,
        CFG_CLIP_HW        = 3'd1,
        CFG_ECHO_LEN       = 3'd2,
        CFG_COMB_LEN_ONE   = 3'd3,
        CFG_COMB_LEN_TWO   = 3'd4,
        CFG_COMB_LEN_THREE = 3'd5,
        CFG_COMB_LEN_FOUR  = 3'd6
    } t_cfg_idx;

    // Register reset values
    localparam logic [EN_BITS-1:0]   ENABLES_RST       = 3'd2;
    localparam logic [CLIP_BITS-1:0] CLIP_HW_RST       = 10'd100;
    localparam logic [LEN_BITS-1:0]  ECHO_LEN_RST      = 17'd50000;
    localparam logic [LEN_BITS-1:0]  COMB_LEN_ONE_RST  = 17'd10000;
    localparam logic [LEN_BITS-1:0]  COMB_LEN_OTHER_RST = 17'd50000;

endpackage

/* src/audio_clip_echo_reverb_chain.sv */
// Clip, echo and four-comb reverb chain built around synchronous sample stores.
//
// Usage:
//   Input channel: i_in_valid / o_in_stall carry one sample (i_sample_in) per
//   transaction. Output channel: o_out_valid / i_out_stall carry one processed
//   sample plus its two 6-bit PWM words per transaction.
//   Configuration: pulse i_cfg_we with i_cfg_index / i_cfg_data while idle.
// Timing:
//   Samples are never taken on consecutive cycles. The echo store is read the
//   cycle the sample is taken and written back the next cycle; the comb stores
//   are read in that write-back cycle (r_v1) and written back in the r_v2
//   cycle, so each store sees one read-modify-write per sample on its single
//   write port. o_out_valid rises once the result has passed r_v1 and r_v2
//   and been written into the output queue.
// Reset:
//   Registers return to their reset values and all five stores are swept to
//   zero, one address per cycle, up to the last address; o_in_stall stays high
//   during the sweep while configuration writes are still taken.
// Backpressure:
//   Results wait in a two-entry output queue. When the receiver stalls the
//   queue fills, and o_in_stall rises once no room is left for another result.
module audio_clip_echo_reverb_chain
    import acer_pkg::*;
#(
    parameter int STORE_WORDS = STORE_WORDS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [SAMPLE_BITS-1:0]   i_sample_in,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [SAMPLE_BITS-1:0]   o_sample_out,
    output logic [PWM_BITS-1:0]      o_pwm_low_word,
    output logic [PWM_BITS-1:0]      o_pwm_high_word
);

    localparam int AW   = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int PW   = ((AW > LEN_BITS) ? AW : LEN_BITS) + 1;
    localparam int DW   = (SAMPLE_BITS > CENTER_BITS) ? SAMPLE_BITS : CENTER_BITS;
    localparam int CDW  = DW - 1;
    localparam int SUMW = DW + 3;
    localparam logic [PW-1:0] WORDS_P   = PW'(STORE_WORDS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_WORDS - 1);
    localparam logic [DW:0]   SAT_MAX   = (DW+1)'((1 << SAMPLE_BITS) - 1);

    // Circular pointer step: wrap at the effective length or at the store end
    function automatic logic [AW-1:0] advance(input logic [AW-1:0] ptr,
                                              input logic [LEN_BITS-1:0] len);
        logic [PW-1:0] nxt;
        nxt = PW'(ptr) + PW'(1);
        if (nxt >= PW'(len) || nxt >= WORDS_P) begin
            advance = '0;
        end else begin
            advance = nxt[AW-1:0];
        end
    endfunction

    // Configuration registers
    logic [EN_BITS-1:0]   r_enables;
    logic [CLIP_BITS-1:0] r_clip_hw;
    logic [LEN_BITS-1:0]  r_echo_len;
    logic [LEN_BITS-1:0]  r_comb_len [COMB_LANES];

    // Control state
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;
    logic          r_v1;
    logic          r_v2;
    logic [1:0]    r_cnt;
    logic          r_wp;
    logic          r_rp;

    // Datapath registers
    logic [DW-1:0]          r_x0;
    logic [DW-1:0]          r_x1;
    logic [AW-1:0]          r_ep;
    logic [AW-1:0]          r_ep_wa;
    logic                   r_e_same;
    logic [DW-1:0]          r_erd_a;
    logic [DW-1:0]          r_erd_b;
    logic [DW-1:0]          r_echo_mem [STORE_WORDS];
    logic [SAMPLE_BITS-1:0] r_q [2];

    logic                   in_acc;
    logic                   out_acc;
    logic                   dist_en;
    logic                   echo_en;
    logic                   rev_en;
    logic [DW-1:0]          clip_hi;
    logic [DW-1:0]          clip_lo;
    logic [DW-1:0]          clip_x;
    logic [AW-1:0]          ep_nxt;
    logic [DW:0]            echo_avg;
    logic [DW-1:0]          echo_new;
    logic [DW-1:0]          echo_tap;
    logic [DW:0]            echo_mix;
    logic [DW-1:0]          x_echo;
    logic                   echo_we;
    logic [AW-1:0]          echo_wa;
    logic [DW-1:0]          echo_wd;
    logic [CDW-1:0]         comb_half;
    logic [CDW-1:0]         comb_tap [COMB_LANES];
    logic [SUMW-1:0]        rev_sum;
    logic [DW-1:0]          x_rev;
    logic [DW:0]            x_dbl;
    logic [SAMPLE_BITS-1:0] result;

    assign dist_en = r_enables[EN_DIST];
    assign echo_en = r_enables[EN_ECHO];
    assign rev_en  = r_enables[EN_REVERB];

    // Handshakes: no intake on consecutive cycles, and only while a result slot is free
    assign o_in_stall = r_clr_busy || r_v1 || (r_cnt == 2'd2) || (r_cnt == 2'd1 && r_v2);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_acc    = o_out_valid && !i_out_stall;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enables     <= ENABLES_RST;
            r_clip_hw     <= CLIP_HW_RST;
            r_echo_len    <= ECHO_LEN_RST;
            r_comb_len[0] <= COMB_LEN_ONE_RST;
            r_comb_len[1] <= COMB_LEN_OTHER_RST;
            r_comb_len[2] <= COMB_LEN_OTHER_RST;
            r_comb_len[3] <= COMB_LEN_OTHER_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ENABLES:        r_enables     <= i_cfg_data[EN_BITS-1:0];
                CFG_CLIP_HW:        r_clip_hw     <= i_cfg_data[CLIP_BITS-1:0];
                CFG_ECHO_LEN:       r_echo_len    <= i_cfg_data[LEN_BITS-1:0];
                CFG_COMB_LEN_ONE:   r_comb_len[0] <= i_cfg_data[LEN_BITS-1:0];
                CFG_COMB_LEN_TWO:   r_comb_len[1] <= i_cfg_data[LEN_BITS-1:0];
                CFG_COMB_LEN_THREE: r_comb_len[2] <= i_cfg_data[LEN_BITS-1:0];
                CFG_COMB_LEN_FOUR:  r_comb_len[3] <= i_cfg_data[LEN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Sweep all stores to zero after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == LAST_ADDR) begin
                r_clr_busy <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= in_acc;
            r_v2 <= r_v1;
        end
    end

    // Clip around the center when distortion is on
    always_comb begin
        clip_hi = DW'(CLIP_CENTER) + DW'(r_clip_hw);
        clip_lo = DW'(CLIP_CENTER) - DW'(r_clip_hw);
        clip_x  = DW'(i_sample_in);
        if (dist_en) begin
            if (clip_x > clip_hi) begin
                clip_x = clip_hi;
            end else if (clip_x < clip_lo) begin
                clip_x = clip_lo;
            end
        end
    end

    assign ep_nxt = advance(r_ep, r_echo_len);

    // Echo pointer: advance on each taken sample while echo is on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ep <= '0;
        end else if (in_acc && echo_en) begin
            r_ep <= ep_nxt;
        end
    end

    // Capture the clipped sample and the echo write address
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x0     <= clip_x;
            r_ep_wa  <= r_ep;
            r_e_same <= (ep_nxt == r_ep);
        end
    end

    // Echo read-modify-write: average into the old entry, mix with the next one
    always_comb begin
        echo_avg = (DW+1)'(r_x0) + (DW+1)'(r_erd_a);
        echo_new = echo_avg[DW:1];
        echo_tap = r_e_same ? echo_new : r_erd_b;
        echo_mix = (DW+1)'(echo_tap) + (DW+1)'(r_x0);
        x_echo   = echo_en ? echo_mix[DW:1] : r_x0;
        echo_we  = r_clr_busy || (r_v1 && echo_en);
        echo_wa  = r_clr_busy ? r_clr_addr : r_ep_wa;
        echo_wd  = r_clr_busy ? '0 : echo_new;
    end

    // Echo store: write back the averaged entry, read both taps on intake
    always_ff @(posedge i_clk) begin
        if (echo_we) begin
            r_echo_mem[echo_wa] <= echo_wd;
        end
        if (in_acc) begin
            r_erd_a <= r_echo_mem[r_ep];
            r_erd_b <= r_echo_mem[ep_nxt];
        end
    end

    // Hand the echo result to the reverb stage
    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_x1 <= x_echo;
        end
    end

    assign comb_half = r_x1[DW-1:1];

    // Comb lanes: each one a store, a pointer and a read-modify-write
    for (genvar k = 0; k < COMB_LANES; k++) begin : g_comb
        logic [AW-1:0]  r_cp;
        logic [AW-1:0]  r_cwa;
        logic           r_c_same;
        logic [CDW-1:0] r_crd_a;
        logic [CDW-1:0] r_crd_b;
        logic [CDW-1:0] r_comb_mem [STORE_WORDS];
        logic [AW-1:0]  cp_nxt;
        logic [CDW:0]   comb_avg;
        logic [CDW-1:0] comb_new;
        logic           comb_we;
        logic [AW-1:0]  comb_wa;
        logic [CDW-1:0] comb_wd;

        assign cp_nxt   = advance(r_cp, r_comb_len[k]);
        assign comb_avg = (CDW+1)'(comb_half) + (CDW+1)'(r_crd_a);
        assign comb_new = comb_avg[CDW:1];
        assign comb_we  = r_clr_busy || (r_v2 && rev_en);
        assign comb_wa  = r_clr_busy ? r_clr_addr : r_cwa;
        assign comb_wd  = r_clr_busy ? '0 : comb_new;
        assign comb_tap[k] = r_c_same ? comb_new : r_crd_b;

        // Advance the lane pointer once per sample while reverb is on
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cp <= '0;
            end else if (r_v1 && rev_en) begin
                r_cp <= cp_nxt;
            end
        end

        // Hold the write address for the next cycle
        always_ff @(posedge i_clk) begin
            if (r_v1) begin
                r_cwa    <= r_cp;
                r_c_same <= (cp_nxt == r_cp);
            end
        end

        // Lane store: write back, read both taps in the echo cycle
        always_ff @(posedge i_clk) begin
            if (comb_we) begin
                r_comb_mem[comb_wa] <= comb_wd;
            end
            if (r_v1) begin
                r_crd_a <= r_comb_mem[r_cp];
                r_crd_b <= r_comb_mem[cp_nxt];
            end
        end
    end

    // Reverb sum, doubling and saturation
    always_comb begin
        rev_sum = SUMW'(r_x1) + SUMW'(comb_tap[0]) + SUMW'(comb_tap[1])
                + SUMW'(comb_tap[2]) + SUMW'(comb_tap[3]);
        x_rev   = rev_en ? DW'(rev_sum >> 2) : r_x1;
        x_dbl   = dist_en ? {x_rev, 1'b0} : {1'b0, x_rev};
        result  = (x_dbl > SAT_MAX) ? SAMPLE_BITS'(SAT_MAX) : x_dbl[SAMPLE_BITS-1:0];
    end

    // Output queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (r_v2) begin
                r_wp <= ~r_wp;
            end
            if (out_acc) begin
                r_rp <= ~r_rp;
            end
            if (r_v2 && !out_acc) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!r_v2 && out_acc) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // Output queue data
    always_ff @(posedge i_clk) begin
        if (r_v2) begin
            r_q[r_wp] <= result;
        end
    end

    assign o_out_valid     = (r_cnt != 2'd0);
    assign o_sample_out    = r_q[r_rp];
    assign o_pwm_low_word  = o_sample_out[PWM_BITS-1:0];
    assign o_pwm_high_word = PWM_BITS'(o_sample_out >> PWM_BITS);

endmodule

/* src/acer_checker.sv */
// Port-level checks for the clip/echo/reverb chain, bound to the top level.
module acer_checker
    import acer_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_stall,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input logic [SAMPLE_BITS-1:0] o_sample_out,
    input logic [PWM_BITS-1:0]    o_pwm_low_word,
    input logic [PWM_BITS-1:0]    o_pwm_high_word
);

    logic in_acc;

    assign in_acc = i_in_valid && !o_in_stall;

    // Reset empties the output and starts the store sweep
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_stall)
        else $error("output valid or input open right after reset");

    // Samples are never taken on consecutive cycles
    a_intake_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !in_acc)
        else $error("input transactions on consecutive cycles");

    // PWM words are the two six-bit slices of the sample
    a_pwm_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pwm_low_word == o_sample_out[PWM_BITS-1:0])
                     && (o_pwm_high_word == PWM_BITS'(o_sample_out >> PWM_BITS)))
        else $error("PWM words do not match the output sample");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_sample_out))
        else $error("stalled output changed");

endmodule

bind audio_clip_echo_reverb_chain acer_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_acer_checker (.*);

/* verif/tb_top.sv */
// Testbench for the clip, echo and four-comb reverb chain: directed and random checks
`timescale 1ns / 1ps

module tb_top;
    import acer_pkg::*;

    localparam int STORE_WORDS   = STORE_WORDS_DEF;
    localparam int SAMPLE_BITS   = SAMPLE_BITS_DEF;
    localparam int SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;
    localparam int PWM_MASK      = (1 << PWM_BITS) - 1;
    localparam int LEN_MAX       = (1 << LEN_BITS) - 1;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int PRESSURE_ITEMS = 30;
    localparam int RANDOM_ITEMS  = 1300;
    localparam int TIMEOUT_NS    = 10_000_000;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic [PWM_BITS-1:0]    pwm_low;
        logic [PWM_BITS-1:0]    pwm_high;
    } t_chain_result;

    logic                     i_clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    t_cfg_idx                 cfg_index = CFG_ENABLES;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic [SAMPLE_BITS-1:0]   sample_in = '0;
    logic                     out_stall = 1'b0;
    logic                     o_in_stall;
    logic                     o_out_valid;
    logic [SAMPLE_BITS-1:0]   o_sample_out;
    logic [PWM_BITS-1:0]      o_pwm_low_word;
    logic [PWM_BITS-1:0]      o_pwm_high_word;

    // Register copies as the block should hold them
    logic [EN_BITS-1:0]   cur_enables = ENABLES_RST;
    logic [CLIP_BITS-1:0] cur_clip_hw = CLIP_HW_RST;
    logic [LEN_BITS-1:0]  cur_echo_len = ECHO_LEN_RST;
    logic [LEN_BITS-1:0]  cur_comb_len [COMB_LANES] = '{COMB_LEN_ONE_RST, COMB_LEN_OTHER_RST,
                                                        COMB_LEN_OTHER_RST, COMB_LEN_OTHER_RST};

    // Store contents and pointers; all start at zero
    bit [11:0] echo_mem [STORE_WORDS];
    bit [10:0] comb_mem [COMB_LANES][STORE_WORDS];
    int        echo_ptr = 0;
    int        comb_ptr [COMB_LANES] = '{0, 0, 0, 0};

    t_chain_result awaited_outputs [$];
    int            mismatch_count = 0;
    int            results_seen = 0;
    bit            send_idle = 1'b1;
    bit            recv_idle = 1'b1;
    bit            hold_pending = 1'b0;
    bit            hold_active = 1'b0;

    audio_clip_echo_reverb_chain uut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_sample_in     (sample_in),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_sample_out    (o_sample_out),
        .o_pwm_low_word  (o_pwm_low_word),
        .o_pwm_high_word (o_pwm_high_word)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("Verification failed");
        $finish;
    end

    // Mostly short idle stretches, a few long ones
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Step a circular pointer, wrapping at the clamped length
    function automatic int wrap_advance(input int ptr, input int len);
        int lim;
        lim = (len > STORE_WORDS) ? STORE_WORDS : len;
        ptr++;
        if (ptr >= lim) ptr = 0;
        if (ptr >= STORE_WORDS) ptr = 0;
        return ptr;
    endfunction

    // Run one sample through clipper, echo and reverb; update the stores
    function automatic t_chain_result run_effect_chain(input logic [SAMPLE_BITS-1:0] value);
        t_chain_result res;
        int x, hi, lo, half, total, p, k;
        bit dist_on;
        x = value;
        dist_on = cur_enables[EN_DIST];
        if (dist_on) begin
            hi = CLIP_CENTER + cur_clip_hw;
            lo = CLIP_CENTER - cur_clip_hw;
            if (x > hi) x = hi;
            if (x < lo) x = lo;
        end
        if (cur_enables[EN_ECHO]) begin
            p = echo_ptr;
            echo_mem[p] = 12'((x + echo_mem[p]) >> 1);
            echo_ptr = wrap_advance(p, cur_echo_len);
            x = (echo_mem[echo_ptr] + x) >> 1;
        end
        if (cur_enables[EN_REVERB]) begin
            half = x >> 1;
            total = x;
            for (k = 0; k < COMB_LANES; k++) begin
                p = comb_ptr[k];
                comb_mem[k][p] = 11'((half + comb_mem[k][p]) >> 1);
                comb_ptr[k] = wrap_advance(p, cur_comb_len[k]);
            end
            for (k = 0; k < COMB_LANES; k++)
                total += comb_mem[k][comb_ptr[k]];
            x = total >> 2;
        end
        if (dist_on) x = x * 2;
        if (x > SAMPLE_MAX) x = SAMPLE_MAX;
        res.sample   = SAMPLE_BITS'(x);
        res.pwm_low  = PWM_BITS'(x & PWM_MASK);
        res.pwm_high = PWM_BITS'((x >> PWM_BITS) & PWM_MASK);
        return res;
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%s", msg);
    endfunction

    // Drive one register write; the write enable stays up for back-to-back writes
    task automatic write_register(input t_cfg_idx idx, input logic [CFG_DATA_BITS-1:0] value);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_ENABLES:        cur_enables = value[EN_BITS-1:0];
            CFG_CLIP_HW:        cur_clip_hw = value[CLIP_BITS-1:0];
            CFG_ECHO_LEN:       cur_echo_len = value[LEN_BITS-1:0];
            CFG_COMB_LEN_ONE:   cur_comb_len[0] = value[LEN_BITS-1:0];
            CFG_COMB_LEN_TWO:   cur_comb_len[1] = value[LEN_BITS-1:0];
            CFG_COMB_LEN_THREE: cur_comb_len[2] = value[LEN_BITS-1:0];
            CFG_COMB_LEN_FOUR:  cur_comb_len[3] = value[LEN_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic close_writes();
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Offer one sample until the block takes it, then record what it must produce
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] value);
        int gap;
        gap = send_idle ? idle_length() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid  <= 1'b1;
        sample_in <= value;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        awaited_outputs.push_back(run_effect_chain(value));
    endtask

    // Drop valid, let every pending result come out, then let the pipeline settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (awaited_outputs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        int r, v;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            v = $urandom_range(0, 1) ? CLIP_CENTER + cur_clip_hw : CLIP_CENTER - cur_clip_hw;
            v = v + $urandom_range(0, 4) - 2;
            if (v < 0) v = 0;
            if (v > SAMPLE_MAX) v = SAMPLE_MAX;
        end else if (r < 25) begin
            v = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
        end else begin
            v = $urandom_range(0, SAMPLE_MAX);
        end
        return SAMPLE_BITS'(v);
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] random_reg_value(input t_cfg_idx idx);
        logic [CFG_DATA_BITS-1:0] v;
        int r;
        bit keep_high;
        v = CFG_DATA_BITS'($urandom());
        r = $urandom_range(0, 99);
        keep_high = ($urandom_range(0, 7) == 0);
        case (idx)
            CFG_ENABLES: begin
                if (!keep_high) v[CFG_DATA_BITS-1:EN_BITS] = '0;
            end
            CFG_CLIP_HW: begin
                if (r < 10) v[CLIP_BITS-1:0] = '0;
                else if (r < 20) v[CLIP_BITS-1:0] = '1;
                if (!keep_high) v[CFG_DATA_BITS-1:CLIP_BITS] = '0;
            end
            default: begin
                if (r < 8) v = 0;
                else if (r < 16) v = 1;
                else if (r < 70) v = CFG_DATA_BITS'($urandom_range(2, 40));
                else if (r < 80) v = CFG_DATA_BITS'($urandom_range(41, 3000));
                else if (r < 85) v = CFG_DATA_BITS'(STORE_WORDS - 1);
                else if (r < 90) v = CFG_DATA_BITS'(STORE_WORDS);
                else if (r < 95) v = CFG_DATA_BITS'(STORE_WORDS + 1);
                else v = CFG_DATA_BITS'($urandom_range(STORE_WORDS + 2, LEN_MAX));
            end
        endcase
        return v;
    endfunction

    // Receiver side: random stalls, or one long hold when a test asks for it
    initial begin : out_stall_drive
        int run;
        @(posedge i_clk);
        forever begin
            if (hold_pending) begin
                hold_pending = 1'b0;
                hold_active  = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_active = 1'b0;
            end else begin
                out_stall <= recv_idle && ($urandom_range(0, 99) < 30);
                run = recv_idle ? idle_length() + 1 : 1;
                repeat (run) @(posedge i_clk);
            end
        end
    end

    // Compare each output transaction with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_chain_result want;
        if (rst_n && o_out_valid && !out_stall) begin
            results_seen++;
            if (awaited_outputs.size() == 0) begin
                note_mismatch($sformatf("result %0d: none expected, got sample=%0d low=%0d high=%0d",
                                        results_seen, o_sample_out, o_pwm_low_word,
                                        o_pwm_high_word));
            end else begin
                want = awaited_outputs.pop_front();
                if (o_sample_out !== want.sample || o_pwm_low_word !== want.pwm_low ||
                    o_pwm_high_word !== want.pwm_high)
                    note_mismatch($sformatf(
                        "result %0d: expected sample=%0d low=%0d high=%0d, got %0d %0d %0d",
                        results_seen, want.sample, want.pwm_low, want.pwm_high,
                        o_sample_out, o_pwm_low_word, o_pwm_high_word));
            end
        end
    end

    // Reset values: echo alone with its long default length
    task automatic test_reset_defaults();
        send_sample(SAMPLE_BITS'(SAMPLE_MAX));
        send_sample(0);
        send_sample(12'hAAA);
        wait_idle();
    endtask

    // Clipper alone at the narrowest, widest and a middle half width
    task automatic test_clipper();
        write_register(CFG_ENABLES, CFG_DATA_BITS'(1 << EN_DIST));
        write_register(CFG_CLIP_HW, 0);
        close_writes();
        send_sample(SAMPLE_BITS'(SAMPLE_MAX));
        send_sample(0);
        wait_idle();
        write_register(CFG_CLIP_HW, CFG_DATA_BITS'((1 << CLIP_BITS) - 1));
        close_writes();
        send_sample(SAMPLE_BITS'(SAMPLE_MAX));
        send_sample(0);
        send_sample(12'h7FF);
        wait_idle();
        write_register(CFG_CLIP_HW, 500);
        close_writes();
        send_sample(SAMPLE_BITS'(CLIP_CENTER + 501));
        send_sample(SAMPLE_BITS'(CLIP_CENTER - 501));
        wait_idle();
    endtask

    // Echo with length zero, an oversized length, and a cut below the pointer
    task automatic test_echo_lengths();
        write_register(CFG_ENABLES, CFG_DATA_BITS'(1 << EN_ECHO));
        write_register(CFG_ECHO_LEN, 0);
        close_writes();
        send_sample(SAMPLE_BITS'(SAMPLE_MAX));
        send_sample(12'h555);
        send_sample(100);
        wait_idle();
        write_register(CFG_ECHO_LEN, CFG_DATA_BITS'(LEN_MAX));
        close_writes();
        send_sample(4000);
        send_sample(1);
        send_sample(2048);
        wait_idle();
        write_register(CFG_ECHO_LEN, 2);
        close_writes();
        send_sample(3000);
        send_sample(SAMPLE_BITS'(SAMPLE_MAX));
        send_sample(0);
        wait_idle();
    endtask

    // Reverb combs at length zero, one, three and oversized; then every stage on
    task automatic test_reverb_combs();
        write_register(CFG_ENABLES, CFG_DATA_BITS'(1 << EN_REVERB));
        write_register(CFG_COMB_LEN_ONE, 0);
        write_register(CFG_COMB_LEN_TWO, 1);
        write_register(CFG_COMB_LEN_THREE, 3);
        write_register(CFG_COMB_LEN_FOUR, CFG_DATA_BITS'(LEN_MAX));
        close_writes();
        send_sample(SAMPLE_BITS'(SAMPLE_MAX));
        send_sample(SAMPLE_BITS'(SAMPLE_MAX));
        send_sample(0);
        send_sample(2500);
        wait_idle();
        write_register(CFG_ENABLES,
                       CFG_DATA_BITS'((1 << EN_DIST) | (1 << EN_ECHO) | (1 << EN_REVERB)));
        write_register(CFG_CLIP_HW, CFG_DATA_BITS'((1 << CLIP_BITS) - 1));
        close_writes();
        send_sample(SAMPLE_BITS'(SAMPLE_MAX));
        send_sample(12'h7FF);
        wait_idle();
    endtask

    // Hold the receiver off while samples keep coming, so the input stalls
    task automatic test_output_backpressure();
        int k;
        send_idle = 1'b0;
        hold_pending = 1'b1;
        wait (hold_active);
        for (k = 0; k < PRESSURE_ITEMS; k++)
            send_sample(SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)));
        wait_idle();
        send_idle = 1'b1;
    endtask

    // Random settings per phase, random samples within each phase
    task automatic test_random_settings();
        int sent, phase_items, k, mode;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            for (k = 0; k <= CFG_COMB_LEN_FOUR; k++)
                if ($urandom_range(0, 99) < 60)
                    write_register(t_cfg_idx'(k), random_reg_value(t_cfg_idx'(k)));
            close_writes();
            mode = $urandom_range(0, 9);
            send_idle = !(mode <= 2);
            recv_idle = !(mode <= 1 || mode == 3);
            phase_items = $urandom_range(10, 60);
            for (k = 0; k < phase_items; k++) begin
                send_sample(pick_sample());
                sent++;
            end
            wait_idle();
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_clipper();
        test_echo_lengths();
        test_reverb_combs();
        test_output_backpressure();
        test_random_settings();
        if (awaited_outputs.size() != 0)
            $display("%0d results never arrived", awaited_outputs.size());
        if (mismatch_count == 0 && awaited_outputs.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
